// ===== rtl/directory_record_parser_assert.svh =====
// Assertion macros shared by the directory record parser modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DIRECTORY_RECORD_PARSER_ASSERT_SVH
`define DIRECTORY_RECORD_PARSER_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define DRP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("directory_record_parser: invariant violated");

// Antecedent implies consequent in the same cycle.
`define DRP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("directory_record_parser: implication violated");

// Antecedent implies consequent in the next cycle.
`define DRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("directory_record_parser: next-cycle check violated");

`endif

// ===== rtl/drp_pkg.sv =====
// ----------------------------------------------------------------------------
// drp_pkg
// Types and constants shared by the directory record parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

  localparam int unsigned HDR_LEN     = 14;
  localparam int unsigned DIR_BIT_POS = 4;      // attribute bit 0x10
  localparam logic [31:0] END_MARK    = 32'hFFFF_FFFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned OUT_TDATA_W = 88;     // 83 field bits, padded to bytes

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_PAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_REC  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_MARK  = 2'd0,
    CAUSE_EXH   = 2'd1,
    CAUSE_TRUNC = 2'd2
  } cause_t;

  // Everything one accepted byte causes: up to a name byte, a record
  // report and a directory end, in that order.
  typedef struct packed {
    logic        has_name;
    logic        has_rec;
    logic        has_end;
    logic [7:0]  name_char;
    logic [31:0] sector;
    logic [31:0] size;
    logic        is_dir;
    logic [7:0]  name_len;
    cause_t      cause;
  } ev_t;

endpackage

`default_nettype wire

// ===== rtl/directory_record_parser.sv =====
// ----------------------------------------------------------------------------
// directory_record_parser
// Streaming parser for directory buffers: name bytes, record reports and a
// directory end indication, produced from one buffer byte per request.
// ----------------------------------------------------------------------------
// The block takes one directory byte per cycle and never stalls the input
// except when its four-entry event queue is full. Each byte causes zero to
// three results (name byte, record complete, directory end); results leave
// through a registered output at one per cycle while out_tready is high,
// so a run of bytes that each cause one result streams at one byte per
// cycle, and the output port alone sets the pace when bytes cause more.
// Header and padding bytes cause results only when they end a record or
// the directory. Run_last (out_tlast) marks the final result caused by
// one input byte. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module directory_record_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input requests
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  wire logic                              in_tlast,   // last_byte
  // result requests
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] name_char, [39:8] rec_sector, [71:40] rec_size, [72] is_dir,
  // [80:73] name_len, [82:81] end_cause, [87:83] zero
  output logic [drp_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic [1:0]                             out_tuser,  // [1:0] kind
  output logic                                   out_tlast   // run_last
);
  import drp_pkg::*;

  // Front end to queue
  logic q_push;
  ev_t  push_ev;
  logic q_not_full;

  // Queue to back end
  logic q_pop;
  ev_t  head_ev;
  logic q_not_empty;

  // Parse bytes and classify each one into an event
  drp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_ev       (push_ev)
  );

  // Hold events so that the parser runs on while results wait
  drp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ev   (push_ev),
    .pop       (q_pop),
    .head_ev   (head_ev),
    .not_full  (q_not_full),
    .not_empty (q_not_empty)
  );

  // Unpack events into results, one per cycle while the output is accepted
  drp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_ev        (head_ev),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/drp_front.sv =====
// ----------------------------------------------------------------------------
// drp_front
// Byte parser: assembles record headers, tracks name and padding bytes and
// classifies each accepted byte into an event for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drp_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // last_byte
  input  wire logic        q_not_full,
  output logic             q_push,
  output drp_pkg::ev_t     q_ev
);
  import drp_pkg::*;

  localparam logic [3:0] HDR_LAST = 4'(HDR_LEN - 1);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [31:0] sub_r, sub_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] size_r, size_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;

  logic        accept;
  logic [31:0] byte_sh;
  logic [1:0]  rec_pad;
  logic        do_name, do_rec, do_end, to_name, pad_done, rearm;
  cause_t      cause;

  assign in_tready = q_not_full;
  assign accept    = in_tvalid && q_not_full;
  assign byte_sh   = {24'd0, in_tdata} << {hidx_r[1:0], 3'b000};

  // Field assembly and event classification
  always_comb begin
    sub_nxt  = sub_r;
    sec_nxt  = sec_r;
    size_nxt = size_r;
    attr_nxt = attr_r;
    len_nxt  = len_r;
    hidx_nxt = hidx_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    do_name  = 1'b0;
    do_rec   = 1'b0;
    do_end   = 1'b0;
    to_name  = 1'b0;
    pad_done = 1'b0;
    rearm    = 1'b0;
    cause    = CAUSE_MARK;
    case (phase_r)
      PH_HEADER: begin
        if (hidx_r == 4'd0) begin
          sub_nxt  = '0;
          sec_nxt  = '0;
          size_nxt = '0;
          attr_nxt = '0;
          len_nxt  = '0;
        end
        case (hidx_r[3:2])
          2'd0:    sub_nxt  = sub_nxt | byte_sh;
          2'd1:    sec_nxt  = sec_nxt | byte_sh;
          2'd2:    size_nxt = size_nxt | byte_sh;
          default: begin
            if (hidx_r[0]) len_nxt = in_tdata;
            else           attr_nxt = in_tdata;
          end
        endcase
        hidx_nxt = hidx_r + 4'd1;
        if (hidx_r == 4'd3 && sub_nxt == END_MARK) begin
          do_end = 1'b1;
          cause  = CAUSE_MARK;
        end else if (hidx_r == HDR_LAST) begin
          cnt_nxt = '0;
          if (in_tdata == 8'd0) begin
            do_rec = 1'b1;
            if (in_tlast) begin
              do_end = 1'b1;
              cause  = CAUSE_EXH;
            end
          end else begin
            to_name = 1'b1;
            if (in_tlast) begin
              do_end = 1'b1;
              cause  = CAUSE_TRUNC;
            end
          end
        end else if (in_tlast) begin
          do_end = 1'b1;
          cause  = CAUSE_TRUNC;
        end
      end
      PH_NAME: begin
        do_name = 1'b1;
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_nxt == len_r) begin
          do_rec = 1'b1;
          if (in_tlast) begin
            do_end = 1'b1;
            cause  = CAUSE_EXH;
          end
        end else if (in_tlast) begin
          do_end = 1'b1;
          cause  = CAUSE_TRUNC;
        end
      end
      PH_PAD: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_nxt == 2'd0) begin
          pad_done = 1'b1;
          hidx_nxt = '0;
        end
        if (in_tlast) begin
          do_end = 1'b1;
          cause  = CAUSE_EXH;
        end
      end
      default: begin
        if (in_tlast) begin
          rearm    = 1'b1;
          hidx_nxt = '0;
        end
      end
    endcase
    // padding brings header plus name to a multiple of four bytes
    rec_pad = 2'd2 - len_nxt[1:0];
    if (do_rec) begin
      pad_nxt  = rec_pad;
      hidx_nxt = '0;
    end
    if (do_end) begin
      hidx_nxt = '0;
      cnt_nxt  = '0;
      pad_nxt  = '0;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: if (to_name)  phase_nxt = PH_NAME;
      PH_NAME:   phase_nxt = PH_NAME;
      PH_PAD:    if (pad_done) phase_nxt = PH_HEADER;
      PH_DONE:   if (rearm)    phase_nxt = PH_HEADER;
      default:   phase_nxt = PH_HEADER;
    endcase
    if (do_rec) begin
      phase_nxt = (rec_pad != 2'd0) ? PH_PAD : PH_HEADER;
    end
    if (do_end) begin
      phase_nxt = in_tlast ? PH_HEADER : PH_DONE;
    end
  end

  // Event towards the queue
  always_comb begin
    q_ev.has_name  = do_name;
    q_ev.has_rec   = do_rec;
    q_ev.has_end   = do_end;
    q_ev.name_char = do_name ? in_tdata : 8'd0;
    q_ev.sector    = do_rec ? sec_nxt : 32'd0;
    q_ev.size      = do_rec ? size_nxt : 32'd0;
    q_ev.is_dir    = do_rec ? attr_nxt[DIR_BIT_POS] : 1'b0;
    q_ev.name_len  = do_rec ? len_nxt : 8'd0;
    q_ev.cause     = do_end ? cause : CAUSE_MARK;
    q_push         = accept && (do_name || do_rec || do_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hidx_r  <= '0;
      cnt_r   <= '0;
      pad_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      cnt_r   <= cnt_nxt;
      pad_r   <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sub_r  <= sub_nxt;
      sec_r  <= sec_nxt;
      size_r <= size_nxt;
      attr_r <= attr_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/drp_queue.sv =====
// ----------------------------------------------------------------------------
// drp_queue
// Short event queue between the byte parser and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drp_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire drp_pkg::ev_t push_ev,
  input  wire logic         pop,
  output drp_pkg::ev_t      head_ev,
  output logic              not_full,
  output logic              not_empty
);
  import drp_pkg::*;

  `include "directory_record_parser_assert.svh"

  localparam logic [QCNT_W-1:0] DEPTH_C = QCNT_W'(QUEUE_DEPTH);
  localparam logic [QCNT_W-1:0] CNT_ONE = QCNT_W'(1);
  localparam logic [QPTR_W-1:0] PTR_ONE = QPTR_W'(1);

  ev_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign not_full  = (count_r != DEPTH_C);
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_ev   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + PTR_ONE : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + PTR_ONE : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CNT_ONE;
    if (do_pop && !do_push) count_nxt = count_r - CNT_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_ev;
  end

  `DRP_ASSERT(a_count_bound, count_r <= DEPTH_C)
  `DRP_ASSERT_IMPL(a_pop_nonempty, pop, count_r != '0)
  `DRP_ASSERT_NEXT(a_push_grows, rst_n && do_push && !do_pop, count_r == $past(count_r) + CNT_ONE)

endmodule

`default_nettype wire

// ===== rtl/drp_back.sv =====
// ----------------------------------------------------------------------------
// drp_back
// Result sequencer: unpacks one event at a time into name, record and end
// results and drives them through the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drp_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_not_empty,
  input  wire drp_pkg::ev_t                      q_ev,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [drp_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast
);
  import drp_pkg::*;

  `include "directory_record_parser_assert.svh"

  ev_t   cur_r;
  logic  cur_name_r, cur_name_nxt;
  logic  cur_rec_r, cur_rec_nxt;
  logic  cur_end_r, cur_end_nxt;
  logic  cur_any, can_load, emit;
  logic  rest_name, rest_rec, rest_end, rest_none;
  kind_t emit_kind;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]             out_user_r, out_user_nxt;
  logic                   out_last_r, out_last_nxt;

  assign cur_any  = cur_name_r || cur_rec_r || cur_end_r;
  assign can_load = !out_valid_r || out_tready;
  assign emit     = can_load && cur_any;

  // Pick the first pending result of the current event
  always_comb begin
    rest_name = cur_name_r;
    rest_rec  = cur_rec_r;
    rest_end  = cur_end_r;
    emit_kind = KIND_END;
    if (cur_name_r) begin
      emit_kind = KIND_NAME;
      rest_name = 1'b0;
    end else if (cur_rec_r) begin
      emit_kind = KIND_REC;
      rest_rec  = 1'b0;
    end else begin
      rest_end  = 1'b0;
    end
    rest_none = !(rest_name || rest_rec || rest_end);
  end

  always_comb begin
    q_pop        = q_not_empty && (!cur_any || (emit && rest_none));
    cur_name_nxt = cur_name_r;
    cur_rec_nxt  = cur_rec_r;
    cur_end_nxt  = cur_end_r;
    if (q_pop) begin
      cur_name_nxt = q_ev.has_name;
      cur_rec_nxt  = q_ev.has_rec;
      cur_end_nxt  = q_ev.has_end;
    end else if (emit) begin
      cur_name_nxt = rest_name;
      cur_rec_nxt  = rest_rec;
      cur_end_nxt  = rest_end;
    end
  end

  // Output word: fields not belonging to the result kind read as zero
  always_comb begin
    out_valid_nxt = can_load ? emit : out_valid_r;
    out_data_nxt  = '0;
    out_user_nxt  = emit_kind;
    out_last_nxt  = rest_none;
    case (emit_kind)
      KIND_NAME: out_data_nxt[7:0] = cur_r.name_char;
      KIND_REC: begin
        out_data_nxt[39:8]  = cur_r.sector;
        out_data_nxt[71:40] = cur_r.size;
        out_data_nxt[72]    = cur_r.is_dir;
        out_data_nxt[80:73] = cur_r.name_len;
      end
      default:   out_data_nxt[82:81] = cur_r.cause;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_name_r  <= 1'b0;
      cur_rec_r   <= 1'b0;
      cur_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_name_r  <= cur_name_nxt;
      cur_rec_r   <= cur_rec_nxt;
      cur_end_r   <= cur_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_ev;
    if (emit) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `DRP_ASSERT_IMPL(a_end_is_last, out_valid_r && out_user_r == KIND_END, out_last_r)
  `DRP_ASSERT_IMPL(a_more_pending, out_valid_r && !out_last_r, cur_any)
  `DRP_ASSERT_NEXT(a_no_gap, rst_n && out_valid_r && out_tready && !out_last_r, out_valid_r)

endmodule

`default_nettype wire
